// File: hw/rtl/awfa_pkg.sv
// Shared types and constants for the address window first-fit allocator.
// Holds the window entry and request structs used by the core and fit check.
// No dependencies.
package awfa_pkg;

    localparam int DEFAULT_MAX_WINDOWS = 16;

    localparam int ADDR_W  = 64;
    localparam int KIND_W  = 2;
    localparam int FLAGS_W = 8;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    localparam logic [FLAGS_W-1:0] PREFETCH_MASK = 8'h06;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  low;
        logic [ADDR_W-1:0]  high;
        logic [FLAGS_W-1:0] flags;
    } window_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] lower_bound;
        logic [ADDR_W-1:0] upper_bound;
        logic              want_prefetch;
        logic [ADDR_W-1:0] alloc_size;
    } alloc_req_t;

endpackage

// File: hw/rtl/awfa_fit.sv
// Fit test of one window entry against an allocation request.
// Depends on awfa_pkg for the entry and request structs.
module awfa_fit
    import awfa_pkg::*;
(
    input  window_entry_t entry,
    input  alloc_req_t    req,
    output logic          fit
);

    logic             kind_ok;
    logic             lower_ok;
    logic             upper_ok;
    logic             prefetch_ok;
    logic             order_ok;
    logic             room_ok;
    logic [ADDR_W-1:0] room;

    always_comb
    begin
        kind_ok     = (entry.kind == req.kind);
        lower_ok    = (req.lower_bound == '0) || (entry.high >= req.lower_bound);
        upper_ok    = (req.upper_bound == '0) || (entry.low <= req.upper_bound);
        prefetch_ok = ((|(entry.flags & PREFETCH_MASK)) == req.want_prefetch);
        // an inverted window has no room at all
        order_ok    = (entry.low <= entry.high);
        room        = entry.high - entry.low;
        room_ok     = (room >= req.alloc_size);
        fit         = kind_ok && lower_ok && upper_ok && prefetch_ok && order_ok && room_ok;
    end

endmodule

// File: hw/rtl/address_window_first_fit_allocator_core.sv
// Address window first-fit allocator: window table memory, scan sequencer, results.
// Depends on awfa_pkg and awfa_fit.
//
// Channel    Direction  Handshake              Payload
// request    in         start & !busy          req_type, entry_index, kind, window_*,
//                                              lower_bound, upper_bound, want_prefetch,
//                                              alloc_size
// result     out        done (one cycle)       granted, base_address, entry_used
// config     in         cfg_write              cfg_data (window_count)
//
// A load transaction writes the table at the accept edge and leaves busy low.
// An allocate transaction scans one table entry per cycle through the memory's
// registered read port, up to min(window_count, MAX_WINDOWS) entries, and stops at
// the first grant; when that limit is 0 it refuses at once without a scan.
// Busy stays high during the scan. The receiver cannot stall: done lasts one cycle.
// Reset clears the FSM and window_count; table contents stay undefined until loaded.
module address_window_first_fit_allocator_core
    import awfa_pkg::*;
#(
    parameter int MAX_WINDOWS = DEFAULT_MAX_WINDOWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [KIND_W-1:0]  kind,
    input  logic [ADDR_W-1:0]  window_start,
    input  logic [ADDR_W-1:0]  window_end,
    input  logic [FLAGS_W-1:0] window_flags,
    input  logic [ADDR_W-1:0]  lower_bound,
    input  logic [ADDR_W-1:0]  upper_bound,
    input  logic               want_prefetch,
    input  logic [ADDR_W-1:0]  alloc_size,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic               done,
    output logic               granted,
    output logic [ADDR_W-1:0]  base_address,
    output logic [INDEX_W-1:0] entry_used
);

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] window_count_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   issue_idx_reg;
    logic [CNT_W-1:0]   check_idx_reg;
    logic               check_valid_reg;
    alloc_req_t         req_reg;
    logic               done_reg;
    logic               granted_reg;
    logic [ADDR_W-1:0]  base_address_reg;
    logic [INDEX_W-1:0] entry_used_reg;

    window_entry_t      table_mem [MAX_WINDOWS];
    window_entry_t      rd_data_reg;

    logic [CNT_W-1:0]   limit_next;
    logic               accept;
    logic               load_fire;
    logic               alloc_fire;
    logic               issue;
    logic               fit;
    logic               hit;
    logic               last_check;
    alloc_req_t         req_in;
    window_entry_t      load_entry;
    window_entry_t      bumped_entry;

    assign busy = (state_reg != ST_IDLE);

    assign accept     = start && !busy;
    assign load_fire  = accept && (req_type == REQ_LOAD) && (int'(entry_index) < MAX_WINDOWS);
    assign alloc_fire = accept && (req_type == REQ_ALLOC);

    always_comb
    begin
        if (int'(window_count_reg) > MAX_WINDOWS)
        begin
            limit_next = CNT_W'(MAX_WINDOWS);
        end
        else
        begin
            limit_next = CNT_W'(window_count_reg);
        end
    end

    always_comb
    begin
        req_in.kind          = kind;
        req_in.lower_bound   = lower_bound;
        req_in.upper_bound   = upper_bound;
        req_in.want_prefetch = want_prefetch;
        req_in.alloc_size    = alloc_size;

        load_entry.kind  = kind;
        load_entry.low   = window_start;
        load_entry.high  = window_end;
        load_entry.flags = window_flags;

        bumped_entry     = rd_data_reg;
        bumped_entry.low = rd_data_reg.low + req_reg.alloc_size;
    end

    awfa_fit u_fit (
        .entry (rd_data_reg),
        .req   (req_reg),
        .fit   (fit)
    );

    assign hit        = (state_reg == ST_SCAN) && check_valid_reg && fit;
    assign last_check = (check_idx_reg + CNT_W'(1)) == limit_reg;
    // stop reading once an entry is granted, so no further entry is fetched
    assign issue      = (state_reg == ST_SCAN) && (issue_idx_reg < limit_reg) && !hit;

    // Table memory: one write port shared by loads and the low-address bump, one
    // registered read port. The scan never writes the entry it reads next.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            table_mem[IDX_W'(entry_index)] <= load_entry;
        end
        else if (hit)
        begin
            table_mem[check_idx_reg[IDX_W-1:0]] <= bumped_entry;
        end
        if (issue)
        begin
            rd_data_reg <= table_mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_fire)
        begin
            req_reg <= req_in;
        end
        if (issue)
        begin
            check_idx_reg <= issue_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_count_reg <= '0;
            limit_reg        <= '0;
            issue_idx_reg    <= '0;
            check_valid_reg  <= 1'b0;
            done_reg         <= 1'b0;
            granted_reg      <= 1'b0;
            base_address_reg <= '0;
            entry_used_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                window_count_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    check_valid_reg <= 1'b0;
                    if (alloc_fire)
                    begin
                        limit_reg     <= limit_next;
                        issue_idx_reg <= '0;
                        if (limit_next == '0)
                        begin
                            // empty table: refuse at once
                            done_reg         <= 1'b1;
                            granted_reg      <= 1'b0;
                            base_address_reg <= '0;
                            entry_used_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    check_valid_reg <= issue;
                    if (issue)
                    begin
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    end
                    if (hit)
                    begin
                        state_reg        <= ST_IDLE;
                        done_reg         <= 1'b1;
                        granted_reg      <= 1'b1;
                        base_address_reg <= rd_data_reg.low;
                        entry_used_reg   <= INDEX_W'(check_idx_reg);
                    end
                    else if (check_valid_reg && last_check)
                    begin
                        state_reg        <= ST_IDLE;
                        done_reg         <= 1'b1;
                        granted_reg      <= 1'b0;
                        base_address_reg <= '0;
                        entry_used_reg   <= '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign base_address = base_address_reg;
    assign entry_used   = entry_used_reg;

    // a result always lands with the sequencer back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while scan still busy");

    // a result follows either a scan or an allocate on an empty table
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_SCAN) || $past(alloc_fire))
        else $error("result strobed without an allocate transaction");

    // a refusal carries zero payload
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (base_address == '0) && (entry_used == '0))
        else $error("refused result with nonzero payload");

    // only entries within the scan limit are ever granted
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (check_idx_reg < limit_reg))
        else $error("grant from an entry beyond the scan limit");

endmodule

// File: sim/awfa_grant_checker.sv
// Grant checker for the address window first-fit allocator: keeps its own window
// table, predicts each allocation grant and compares it with the result strobes.
// Depends on awfa_pkg; instantiated beside the core by the testbench top.
module awfa_grant_checker
    import awfa_pkg::*;
#(
    parameter int MAX_WINDOWS = DEFAULT_MAX_WINDOWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               req_type,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [KIND_W-1:0]  kind,
    input  logic [ADDR_W-1:0]  window_start,
    input  logic [ADDR_W-1:0]  window_end,
    input  logic [FLAGS_W-1:0] window_flags,
    input  logic [ADDR_W-1:0]  lower_bound,
    input  logic [ADDR_W-1:0]  upper_bound,
    input  logic               want_prefetch,
    input  logic [ADDR_W-1:0]  alloc_size,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               done,
    input  logic               granted,
    input  logic [ADDR_W-1:0]  base_address,
    input  logic [INDEX_W-1:0] entry_used,
    output int                 mismatches,
    output int                 pending_grants
);

    typedef struct packed {
        logic               granted;
        logic [ADDR_W-1:0]  base;
        logic [INDEX_W-1:0] entry;
    } grant_t;

    window_entry_t      windows [MAX_WINDOWS];
    logic [COUNT_W-1:0] scan_count;
    grant_t             expected_grants [$];
    grant_t             oldest;
    alloc_req_t         req;

    function automatic bit window_fits(input window_entry_t w, input alloc_req_t r);
        bit is_prefetch;
        is_prefetch = (w.flags & PREFETCH_MASK) != '0;
        if (w.kind != r.kind)
            return 1'b0;
        if (r.lower_bound != '0 && w.high < r.lower_bound)
            return 1'b0;
        if (r.upper_bound != '0 && w.low > r.upper_bound)
            return 1'b0;
        if (is_prefetch != r.want_prefetch)
            return 1'b0;
        // inverted windows have no room at all
        if (w.low > w.high)
            return 1'b0;
        return (w.high - w.low) >= r.alloc_size;
    endfunction

    task automatic serve_allocation(input alloc_req_t r);
        grant_t g;
        int     reach;
        g = '0;
        reach = (int'(scan_count) > MAX_WINDOWS) ? MAX_WINDOWS : int'(scan_count);
        for (int i = 0; i < reach && !g.granted; i++)
        begin
            if (window_fits(windows[i], r))
            begin
                g.granted = 1'b1;
                g.base    = windows[i].low;
                g.entry   = INDEX_W'(i);
                // advance the window past the granted range
                windows[i].low = windows[i].low + r.alloc_size;
            end
        end
        expected_grants.push_back(g);
    endtask

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_count = '0;
            expected_grants.delete();
            mismatches = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("unexpected result", base_address, '0);
                else
                begin
                    oldest = expected_grants.pop_front();
                    if (granted !== oldest.granted)
                        report_mismatch("granted", granted, oldest.granted);
                    if (base_address !== oldest.base)
                        report_mismatch("base_address", base_address, oldest.base);
                    if (entry_used !== oldest.entry)
                        report_mismatch("entry_used", entry_used, oldest.entry);
                end
            end
            if (cfg_write)
                scan_count = cfg_data;
            if (start && !busy)
            begin
                if (req_type == REQ_LOAD)
                begin
                    if (int'(entry_index) < MAX_WINDOWS)
                    begin
                        windows[entry_index].kind  = kind;
                        windows[entry_index].low   = window_start;
                        windows[entry_index].high  = window_end;
                        windows[entry_index].flags = window_flags;
                    end
                end
                else
                begin
                    req.kind          = kind;
                    req.lower_bound   = lower_bound;
                    req.upper_bound   = upper_bound;
                    req.want_prefetch = want_prefetch;
                    req.alloc_size    = alloc_size;
                    serve_allocation(req);
                end
            end
        end
        pending_grants = expected_grants.size();
    end

endmodule

// File: sim/tb_address_window_first_fit_allocator_core.sv
// Testbench top for the address window first-fit allocator core: clock, reset,
// directed and random load/allocate transactions, window count phases, verdict.
// Depends on awfa_pkg, the core and awfa_grant_checker.
module tb_address_window_first_fit_allocator_core
    import awfa_pkg::*;
();

    localparam int TABLE_DEPTH   = DEFAULT_MAX_WINDOWS;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 173;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [KIND_W-1:0] KIND_MEM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IO    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUS   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic               req_type      = REQ_LOAD;
    logic [INDEX_W-1:0] entry_index   = '0;
    logic [KIND_W-1:0]  kind          = KIND_MEM;
    logic [ADDR_W-1:0]  window_start  = '0;
    logic [ADDR_W-1:0]  window_end    = '0;
    logic [FLAGS_W-1:0] window_flags  = '0;
    logic [ADDR_W-1:0]  lower_bound   = '0;
    logic [ADDR_W-1:0]  upper_bound   = '0;
    logic               want_prefetch = 1'b0;
    logic [ADDR_W-1:0]  alloc_size    = '0;
    logic               cfg_write     = 1'b0;
    logic [COUNT_W-1:0] cfg_data      = '0;
    logic               done;
    logic               granted;
    logic [ADDR_W-1:0]  base_address;
    logic [INDEX_W-1:0] entry_used;

    int            mismatches;
    int            pending_grants;
    int            cycle_count = 0;
    bit            idle_on     = 1'b0;
    int            scan_depth  = 0;
    window_entry_t loaded [TABLE_DEPTH];
    int            phase_count [PHASES] = '{16, 31, 1, 17, 9, 16, 24, 3, 20, 16};

    address_window_first_fit_allocator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .kind          (kind),
        .window_start  (window_start),
        .window_end    (window_end),
        .window_flags  (window_flags),
        .lower_bound   (lower_bound),
        .upper_bound   (upper_bound),
        .want_prefetch (want_prefetch),
        .alloc_size    (alloc_size),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .done          (done),
        .granted       (granted),
        .base_address  (base_address),
        .entry_used    (entry_used)
    );

    awfa_grant_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .kind           (kind),
        .window_start   (window_start),
        .window_end     (window_end),
        .window_flags   (window_flags),
        .lower_bound    (lower_bound),
        .upper_bound    (upper_bound),
        .want_prefetch  (want_prefetch),
        .alloc_size     (alloc_size),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .done           (done),
        .granted        (granted),
        .base_address   (base_address),
        .entry_used     (entry_used),
        .mismatches     (mismatches),
        .pending_grants (pending_grants)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("address_window_first_fit_allocator_core verification failed");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic window_entry_t rand_window();
        window_entry_t     w;
        logic [ADDR_W-1:0] span;
        w.kind  = KIND_W'($urandom_range(0, 3));
        w.flags = FLAGS_W'($urandom);
        w.low   = rand64();
        span    = ADDR_W'($urandom_range(16, 1 << 20));
        case ($urandom_range(0, 9))
            0: w.high = rand64();
            1:
            begin
                w.low  = ALL_ONES - ADDR_W'($urandom_range(0, 4096));
                w.high = ALL_ONES;
            end
            2: w.high = w.low - ADDR_W'($urandom_range(1, 4096));
            3:
            begin
                w.low  = '0;
                w.high = span;
            end
            default: w.high = (w.low > ALL_ONES - span) ? ALL_ONES : w.low + span;
        endcase
        return w;
    endfunction

    // Hold the transaction until the core takes it, then maybe drop start for a burst.
    task automatic send(input logic rt, input logic [INDEX_W-1:0] idx,
                        input window_entry_t w, input alloc_req_t r);
        start         <= 1'b1;
        req_type      <= rt;
        entry_index   <= idx;
        kind          <= (rt == REQ_LOAD) ? w.kind : r.kind;
        window_start  <= w.low;
        window_end    <= w.high;
        window_flags  <= w.flags;
        lower_bound   <= r.lower_bound;
        upper_bound   <= r.upper_bound;
        want_prefetch <= r.want_prefetch;
        alloc_size    <= r.alloc_size;
        do
            @(posedge clk);
        while (busy);
        if (rt == REQ_LOAD)
            loaded[idx] = w;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic load_window(input logic [INDEX_W-1:0] idx, input window_entry_t w);
        alloc_req_t r;
        r.kind          = KIND_W'($urandom);
        r.lower_bound   = rand64();
        r.upper_bound   = rand64();
        r.want_prefetch = 1'($urandom);
        r.alloc_size    = rand64();
        send(REQ_LOAD, idx, w, r);
    endtask

    task automatic request_alloc(input alloc_req_t r);
        send(REQ_ALLOC, INDEX_W'($urandom), rand_window(), r);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_grants != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window_count(input int count);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= COUNT_W'(count);
        @(posedge clk);
        cfg_write  <= 1'b0;
        scan_depth = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    endtask

    initial
    begin
        alloc_req_t    r;
        window_entry_t w;
        int            pick;
        int            j;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty scan: nothing is searched while the count is zero
        r = '{kind: KIND_MEM, lower_bound: '0, upper_bound: '0, want_prefetch: 1'b0,
              alloc_size: '0};
        request_alloc(r);

        load_window(0, '{kind: KIND_MEM, low: 64'h1000, high: 64'h1fff, flags: 8'h00});
        load_window(1, '{kind: KIND_MEM, low: 64'h8000_0000, high: 64'hffff_ffff,
                         flags: 8'h02});
        load_window(2, '{kind: KIND_IO, low: 64'h100, high: 64'hffff, flags: 8'h00});
        load_window(3, '{kind: KIND_BUS, low: 64'h1, high: 64'hff, flags: 8'h00});
        load_window(4, '{kind: KIND_OTHER, low: '0, high: ALL_ONES, flags: 8'hff});
        load_window(5, '{kind: KIND_MEM, low: 64'h9000, high: 64'h8000, flags: 8'h00});
        load_window(6, '{kind: KIND_IO, low: ALL_ONES, high: ALL_ONES, flags: 8'h04});
        for (int i = 7; i < TABLE_DEPTH; i++)
            load_window(INDEX_W'(i), rand_window());

        set_window_count(TABLE_DEPTH);
        // zero size: first matching window grants and keeps its low address
        request_alloc('{kind: KIND_MEM, lower_bound: '0, upper_bound: '0,
                        want_prefetch: 1'b0, alloc_size: '0});
        request_alloc('{kind: KIND_MEM, lower_bound: 64'h8000_0000, upper_bound: '0,
                        want_prefetch: 1'b1, alloc_size: 64'h100});
        request_alloc('{kind: KIND_IO, lower_bound: '0, upper_bound: 64'h200,
                        want_prefetch: 1'b0, alloc_size: 64'h10});
        request_alloc('{kind: KIND_OTHER, lower_bound: '0, upper_bound: '0,
                        want_prefetch: 1'b1, alloc_size: ALL_ONES});
        request_alloc('{kind: KIND_IO, lower_bound: ALL_ONES, upper_bound: ALL_ONES,
                        want_prefetch: 1'b1, alloc_size: '0});
        request_alloc('{kind: KIND_BUS, lower_bound: '0, upper_bound: '0,
                        want_prefetch: 1'b0, alloc_size: 64'h1000});
        request_alloc('{kind: KIND_MEM, lower_bound: '0, upper_bound: '0,
                        want_prefetch: 1'b0, alloc_size: ALL_ONES});

        for (int p = 0; p < PHASES; p++)
        begin
            set_window_count(phase_count[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // no idling in the closing phase
                if (n % 32 == 0)
                    idle_on = (p != PHASES - 1) && ($urandom_range(0, 1) == 1);
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    load_window(INDEX_W'($urandom), rand_window());
                else if (pick < 25)
                begin
                    r.kind          = KIND_W'($urandom);
                    r.lower_bound   = $urandom_range(0, 1) ? rand64() : '0;
                    r.upper_bound   = $urandom_range(0, 1) ? rand64() : '0;
                    r.want_prefetch = 1'($urandom);
                    r.alloc_size    = $urandom_range(0, 1) ? rand64()
                                                           : ADDR_W'($urandom_range(0, 65535));
                    request_alloc(r);
                end
                else
                begin
                    // aim at a window in the scanned range so grants stay common
                    j = $urandom_range(0, scan_depth - 1);
                    w = loaded[j];
                    r.kind          = w.kind;
                    r.want_prefetch = (w.flags & PREFETCH_MASK) != '0;
                    case ($urandom_range(0, 9))
                        0: r.alloc_size = '0;
                        1: r.alloc_size = rand64();
                        2, 3: r.alloc_size = (w.high - w.low) >> $urandom_range(0, 4);
                        default: r.alloc_size = ADDR_W'($urandom_range(1, 4096));
                    endcase
                    case ($urandom_range(0, 4))
                        0: r.lower_bound = w.high + ADDR_W'($urandom_range(0, 2)) - 1;
                        1: r.lower_bound = rand64();
                        default: r.lower_bound = '0;
                    endcase
                    case ($urandom_range(0, 4))
                        0: r.upper_bound = w.low + ADDR_W'($urandom_range(0, 2)) - 1;
                        1: r.upper_bound = rand64();
                        default: r.upper_bound = '0;
                    endcase
                    request_alloc(r);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("address_window_first_fit_allocator_core verification clean");
        else
            $display("address_window_first_fit_allocator_core verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/awfa_pkg.sv
hw/rtl/awfa_fit.sv
hw/rtl/address_window_first_fit_allocator_core.sv
sim/awfa_grant_checker.sv
sim/tb_address_window_first_fit_allocator_core.sv
